FILE: hdl/pft_pkg.sv
// ============================================================================
// pft_pkg: shared types and constants for the planar frame transform.
// Holds the channel payload structs, the CORDIC angle table and the inverse
// gain table.
// ============================================================================
package pft_pkg;

    localparam int COORD_W  = 32;
    localparam int QUAT_W   = 16;
    localparam int HEAD_W   = 16;
    localparam int GUARD    = 8;
    // Vector width: coordinate difference (33 bits), guard bits, CORDIC growth.
    localparam int VEC_W    = 45;
    // Yaw vector width: sums of squared Q1.14 terms plus CORDIC growth.
    localparam int AV_W     = 36;
    // Angle accumulator in units of 2^-24 rad.
    localparam int ANG_W    = 28;
    localparam int MAX_ITER = 24;

    localparam logic signed [ANG_W-1:0] HALF_PI_Q24   = 28'sd26353589;
    localparam logic signed [HEAD_W-1:0] HEADING_LIMIT = 16'sd25736;

    typedef struct packed {
        logic                      func;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic signed [QUAT_W-1:0]  quat_x;
        logic signed [QUAT_W-1:0]  quat_y;
        logic signed [QUAT_W-1:0]  quat_z;
        logic signed [QUAT_W-1:0]  quat_w;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] result_x;
        logic signed [COORD_W-1:0] result_y;
        logic signed [HEAD_W-1:0]  heading;
        logic                      clipped;
    } t_out_item;

    // Arctangent of 2^-i in units of 2^-24 rad.
    function automatic logic signed [ANG_W-1:0] atan_q24(input int i);
        logic signed [ANG_W-1:0] v;
        case (i)
            0:  v = 28'sd13176795;
            1:  v = 28'sd7778716;
            2:  v = 28'sd4110060;
            3:  v = 28'sd2086331;
            4:  v = 28'sd1047214;
            5:  v = 28'sd524117;
            6:  v = 28'sd262123;
            7:  v = 28'sd131069;
            default: v = ANG_W'(28'sd65536 >>> (i - 8));
        endcase
        return v;
    endfunction

    // Inverse CORDIC gain in Q2.30 for a given iteration count.
    function automatic logic [31:0] inv_gain(input int n);
        logic [31:0] v;
        case (n)
            8:  v = 32'd652039507;
            9:  v = 32'd652034532;
            10: v = 32'd652033289;
            11: v = 32'd652032978;
            12: v = 32'd652032900;
            13: v = 32'd652032881;
            14: v = 32'd652032876;
            default: v = 32'd652032874;
        endcase
        return v;
    endfunction

endpackage

FILE: hdl/planar_frame_transform.sv
// ============================================================================
// planar_frame_transform: 2D rigid transform driven by a quaternion yaw.
// Pipelined CORDIC that derives yaw and rotates the point in lockstep.
// ============================================================================
// The block takes one transfer per cycle unless stalled and returns one result
// per item. Its registers, in order, are one for the quaternion products, one
// for the yaw vector and origin subtraction, one for the quarter-turn, one per
// CORDIC micro-rotation (N of them, the clamped iteration count, default 16),
// two for the gain multiply, and one for origin add and saturation feeding the
// output register. Valid bits ride with each stage and the whole pipeline
// advances whenever the output register is free or being taken, so a stall
// neither drops nor repeats anything.
module planar_frame_transform
    import pft_pkg::*;
#(
    parameter int ANGLE_ITERATIONS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);

    localparam int N = (ANGLE_ITERATIONS < 8) ? 8 :
                       ((ANGLE_ITERATIONS > MAX_ITER) ? MAX_ITER : ANGLE_ITERATIONS);
    localparam logic [31:0] K_GAIN = inv_gain(N);
    localparam int SH = 30 + GUARD;

    logic adv;
    assign adv     = !o_valid || i_ready;
    assign o_ready = adv;

    // Stage 1: quaternion products.
    logic                      r1_v, r1_f;
    logic signed [31:0]        r1_ww, r1_xx, r1_yy, r1_zz, r1_xy, r1_wz;
    logic signed [COORD_W-1:0] r1_px, r1_py, r1_ox, r1_oy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (adv) r1_v <= i_valid;
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_f  <= i_data.func;
            r1_ww <= 32'(i_data.quat_w * i_data.quat_w);
            r1_xx <= 32'(i_data.quat_x * i_data.quat_x);
            r1_yy <= 32'(i_data.quat_y * i_data.quat_y);
            r1_zz <= 32'(i_data.quat_z * i_data.quat_z);
            r1_xy <= 32'(i_data.quat_x * i_data.quat_y);
            r1_wz <= 32'(i_data.quat_w * i_data.quat_z);
            r1_px <= i_data.point_x;
            r1_py <= i_data.point_y;
            r1_ox <= i_data.origin_x;
            r1_oy <= i_data.origin_y;
        end
    end

    // Stage 2: yaw vector and the vector to rotate.
    logic                      r2_v, r2_f;
    logic signed [AV_W-1:0]    r2_ax, r2_ay;
    logic signed [VEC_W-1:0]   r2_bx, r2_by;
    logic signed [COORD_W-1:0] r2_ox, r2_oy;
    logic signed [COORD_W:0]   n2_vx, n2_vy;
    always_comb begin
        n2_vx = r1_f ? (COORD_W+1)'(r1_px) : (COORD_W+1)'(r1_px) - (COORD_W+1)'(r1_ox);
        n2_vy = r1_f ? (COORD_W+1)'(r1_py) : (COORD_W+1)'(r1_py) - (COORD_W+1)'(r1_oy);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else if (adv) r2_v <= r1_v;
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_f  <= r1_f;
            r2_ax <= AV_W'(r1_ww) + AV_W'(r1_xx) - AV_W'(r1_yy) - AV_W'(r1_zz);
            r2_ay <= (AV_W'(r1_xy) + AV_W'(r1_wz)) <<< 1;
            r2_bx <= VEC_W'(n2_vx) <<< GUARD;
            r2_by <= VEC_W'(n2_vy) <<< GUARD;
            r2_ox <= r1_ox;
            r2_oy <= r1_oy;
        end
    end

    // Stage 3: quarter turn into the right half plane; flag the zero vector.
    logic                      r3_v, r3_f, r3_zero;
    logic signed [AV_W-1:0]    r3_ax, r3_ay;
    logic signed [VEC_W-1:0]   r3_bx, r3_by, r3_vx, r3_vy;
    logic signed [ANG_W-1:0]   r3_z;
    logic signed [COORD_W-1:0] r3_ox, r3_oy;
    logic                      n3_up, n3_bcw;
    always_comb begin
        n3_up  = !r2_ay[AV_W-1];
        n3_bcw = n3_up != r2_f;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else if (adv) r3_v <= r2_v;
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_f    <= r2_f;
            r3_zero <= (r2_ax == '0) && (r2_ay == '0);
            r3_vx   <= r2_bx;
            r3_vy   <= r2_by;
            r3_ox   <= r2_ox;
            r3_oy   <= r2_oy;
            if (r2_ax[AV_W-1]) begin
                r3_ax <= n3_up ? r2_ay : -r2_ay;
                r3_ay <= n3_up ? -r2_ax : r2_ax;
                r3_z  <= n3_up ? HALF_PI_Q24 : -HALF_PI_Q24;
                r3_bx <= n3_bcw ? r2_by : -r2_by;
                r3_by <= n3_bcw ? -r2_bx : r2_bx;
            end else begin
                r3_ax <= r2_ax;
                r3_ay <= r2_ay;
                r3_z  <= '0;
                r3_bx <= r2_bx;
                r3_by <= r2_by;
            end
        end
    end

    // CORDIC stages, one micro-rotation per register.
    logic                      c_v   [N+1];
    logic                      c_f   [N+1];
    logic                      c_zr  [N+1];
    logic signed [AV_W-1:0]    c_ax  [N+1];
    logic signed [AV_W-1:0]    c_ay  [N+1];
    logic signed [VEC_W-1:0]   c_bx  [N+1];
    logic signed [VEC_W-1:0]   c_by  [N+1];
    logic signed [VEC_W-1:0]   c_vx  [N+1];
    logic signed [VEC_W-1:0]   c_vy  [N+1];
    logic signed [ANG_W-1:0]   c_z   [N+1];
    logic signed [COORD_W-1:0] c_ox  [N+1];
    logic signed [COORD_W-1:0] c_oy  [N+1];

    assign c_v[0]  = r3_v;
    assign c_f[0]  = r3_f;
    assign c_zr[0] = r3_zero;
    assign c_ax[0] = r3_ax;
    assign c_ay[0] = r3_ay;
    assign c_bx[0] = r3_bx;
    assign c_by[0] = r3_by;
    assign c_vx[0] = r3_vx;
    assign c_vy[0] = r3_vy;
    assign c_z[0]  = r3_z;
    assign c_ox[0] = r3_ox;
    assign c_oy[0] = r3_oy;

    for (genvar g = 0; g < N; g++) begin : g_cordic
        logic r_v, r_f, r_zr;
        logic signed [AV_W-1:0]    r_ax, r_ay;
        logic signed [VEC_W-1:0]   r_bx, r_by, r_vx, r_vy;
        logic signed [ANG_W-1:0]   r_z;
        logic signed [COORD_W-1:0] r_ox, r_oy;
        logic fwd, bneg;
        assign fwd  = !c_ay[g][AV_W-1];
        assign bneg = fwd != c_f[g];
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v <= 1'b0;
            else if (adv) r_v <= c_v[g];
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_f  <= c_f[g];
                r_zr <= c_zr[g];
                r_vx <= c_vx[g];
                r_vy <= c_vy[g];
                r_ox <= c_ox[g];
                r_oy <= c_oy[g];
                if (fwd) begin
                    r_ax <= c_ax[g] + (c_ay[g] >>> g);
                    r_ay <= c_ay[g] - (c_ax[g] >>> g);
                    r_z  <= c_z[g] + atan_q24(g);
                end else begin
                    r_ax <= c_ax[g] - (c_ay[g] >>> g);
                    r_ay <= c_ay[g] + (c_ax[g] >>> g);
                    r_z  <= c_z[g] - atan_q24(g);
                end
                if (bneg) begin
                    r_bx <= c_bx[g] + (c_by[g] >>> g);
                    r_by <= c_by[g] - (c_bx[g] >>> g);
                end else begin
                    r_bx <= c_bx[g] - (c_by[g] >>> g);
                    r_by <= c_by[g] + (c_bx[g] >>> g);
                end
            end
        end
        assign c_v[g+1]  = r_v;
        assign c_f[g+1]  = r_f;
        assign c_zr[g+1] = r_zr;
        assign c_ax[g+1] = r_ax;
        assign c_ay[g+1] = r_ay;
        assign c_bx[g+1] = r_bx;
        assign c_by[g+1] = r_by;
        assign c_vx[g+1] = r_vx;
        assign c_vy[g+1] = r_vy;
        assign c_z[g+1]  = r_z;
        assign c_ox[g+1] = r_ox;
        assign c_oy[g+1] = r_oy;
    end

    // Gain stage A: split magnitude at bit 32 into high and low parts and multiply.
    logic                      ra_v, ra_f, ra_zr, ra_nx, ra_ny;
    logic [63:0]               ra_hx, ra_lx, ra_hy, ra_ly;
    logic signed [VEC_W-1:0]   ra_vx, ra_vy;
    logic signed [ANG_W-1:0]   ra_z;
    logic signed [COORD_W-1:0] ra_ox, ra_oy;
    logic [VEC_W-1:0]          na_mx, na_my;
    always_comb begin
        na_mx = c_bx[N][VEC_W-1] ? VEC_W'(-c_bx[N]) : VEC_W'(c_bx[N]);
        na_my = c_by[N][VEC_W-1] ? VEC_W'(-c_by[N]) : VEC_W'(c_by[N]);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) ra_v <= 1'b0;
        else if (adv) ra_v <= c_v[N];
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            ra_f  <= c_f[N];
            ra_zr <= c_zr[N];
            ra_nx <= c_bx[N][VEC_W-1];
            ra_ny <= c_by[N][VEC_W-1];
            ra_hx <= 64'(na_mx[VEC_W-1:32]) * 64'(K_GAIN);
            ra_lx <= 64'(na_mx[31:0]) * 64'(K_GAIN);
            ra_hy <= 64'(na_my[VEC_W-1:32]) * 64'(K_GAIN);
            ra_ly <= 64'(na_my[31:0]) * 64'(K_GAIN);
            ra_vx <= c_vx[N];
            ra_vy <= c_vy[N];
            ra_z  <= c_z[N];
            ra_ox <= c_ox[N];
            ra_oy <= c_oy[N];
        end
    end

    // Gain stage B: combine partial products, round, restore sign, heading.
    logic                      rb_v, rb_f;
    logic signed [COORD_W+1:0] rb_rx, rb_ry;
    logic signed [HEAD_W-1:0]  rb_head;
    logic signed [COORD_W-1:0] rb_ox, rb_oy;
    logic [63:0]               nb_sx, nb_sy, nb_rx, nb_ry;
    logic signed [ANG_W-1:0]   nb_h;
    logic signed [ANG_W-12:0]  nb_hs;
    always_comb begin
        nb_sx = ((ra_hx & ((64'd1 << (SH-32)) - 64'd1)) << 32) + ra_lx + (64'd1 << (SH-1));
        nb_sy = ((ra_hy & ((64'd1 << (SH-32)) - 64'd1)) << 32) + ra_ly + (64'd1 << (SH-1));
        nb_rx = (ra_hx >> (SH-32)) + (nb_sx >> SH);
        nb_ry = (ra_hy >> (SH-32)) + (nb_sy >> SH);
        nb_h  = ra_z + ANG_W'(1024);
        nb_hs = nb_h[ANG_W-1:11];
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) rb_v <= 1'b0;
        else if (adv) rb_v <= ra_v;
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            rb_f  <= ra_f;
            rb_ox <= ra_ox;
            rb_oy <= ra_oy;
            if (ra_zr) begin
                rb_rx   <= (COORD_W+2)'(ra_vx >>> GUARD);
                rb_ry   <= (COORD_W+2)'(ra_vy >>> GUARD);
                rb_head <= '0;
            end else begin
                rb_rx <= ra_nx ? -(COORD_W+2)'(nb_rx) : (COORD_W+2)'(nb_rx);
                rb_ry <= ra_ny ? -(COORD_W+2)'(nb_ry) : (COORD_W+2)'(nb_ry);
                if (nb_hs > (ANG_W-11)'(HEADING_LIMIT))
                    rb_head <= HEADING_LIMIT;
                else if (nb_hs < -(ANG_W-11)'(HEADING_LIMIT))
                    rb_head <= -HEADING_LIMIT;
                else
                    rb_head <= HEAD_W'(nb_hs);
            end
        end
    end

    // Output stage: origin add, saturation and the output register.
    logic signed [COORD_W+2:0] nc_x, nc_y;
    logic                      nc_cx, nc_cy;
    t_out_item                 r_out;
    logic                      r_ov;
    always_comb begin
        nc_x  = (COORD_W+3)'(rb_rx) + (rb_f ? (COORD_W+3)'(rb_ox) : '0);
        nc_y  = (COORD_W+3)'(rb_ry) + (rb_f ? (COORD_W+3)'(rb_oy) : '0);
        nc_cx = nc_x[COORD_W+2:COORD_W-1] != {4{nc_x[COORD_W+2]}};
        nc_cy = nc_y[COORD_W+2:COORD_W-1] != {4{nc_y[COORD_W+2]}};
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (adv) r_ov <= rb_v;
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.result_x <= nc_cx ? {nc_x[COORD_W+2], {(COORD_W-1){!nc_x[COORD_W+2]}}}
                                    : nc_x[COORD_W-1:0];
            r_out.result_y <= nc_cy ? {nc_y[COORD_W+2], {(COORD_W-1){!nc_y[COORD_W+2]}}}
                                    : nc_y[COORD_W-1:0];
            r_out.heading  <= rb_head;
            r_out.clipped  <= nc_cx || nc_cy;
        end
    end
    assign o_valid = r_ov;
    assign o_data  = r_out;

    // The output holds while stalled, since the pipeline only moves on adv.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("output changed during stall");
    // Heading stays within its clamp.
    a_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.heading <= HEADING_LIMIT) && (o_data.heading >= -HEADING_LIMIT))
        else $error("heading out of range");
    // A clipped result sits at a rail.
    a_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.clipped |->
            (o_data.result_x == 32'sh7fffffff) || (o_data.result_x == 32'sh80000000) ||
            (o_data.result_y == 32'sh7fffffff) || (o_data.result_y == 32'sh80000000))
        else $error("clipped without saturation");

endmodule

FILE: tb/pft_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// pft_checker: result predictor and scoreboard for the planar frame transform.
// Watches both channels, computes the expected transform of every accepted
// input transfer and compares each output transfer field by field in order.
// ============================================================================
module pft_checker
    import pft_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_data,
    output int        o_errors,
    output int        o_pending
);

    localparam int ITERS = 16;
    localparam longint HALF_PI = 64'sd26353589;
    localparam longint HEAD_MAX = 64'sd25736;

    t_out_item transform_q[$];

    // Arithmetic shift right that floors, as the hardware does.
    function automatic longint shr(input longint v, input int s);
        return v >>> s;
    endfunction

    // Multiply by inverse gain and drop 38 fraction bits, rounding half away
    // from zero.
    function automatic longint gain_round(input longint v, input longint k);
        logic [127:0] m;
        logic [127:0] p;
        logic neg;
        neg = v < 0;
        m = neg ? 128'(-v) : 128'(v);
        p = (m * 128'(k) + (128'd1 << 37)) >> 38;
        return neg ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint angle_step(input int i);
        longint tab [8];
        tab = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123,
                131069};
        return (i < 8) ? tab[i] : (64'sd65536 >>> (i - 8));
    endfunction

    function automatic t_out_item predict_transform(input t_in_item d);
        t_out_item r;
        logic glob;
        longint px, py, ox, oy, qx, qy, qz, qw;
        longint cy, sy, vx, vy, rx, ry, hd;
        longint ax, ay, z, bx, by, tx, tb;
        logic up, fwd, clip;
        glob = d.func;
        px = d.point_x; py = d.point_y; ox = d.origin_x; oy = d.origin_y;
        qx = d.quat_x; qy = d.quat_y; qz = d.quat_z; qw = d.quat_w;
        cy = qw * qw + qx * qx - qy * qy - qz * qz;
        sy = 2 * (qx * qy + qw * qz);
        vx = glob ? px : px - ox;
        vy = glob ? py : py - oy;
        rx = vx; ry = vy; hd = 0; clip = 1'b0;
        if (cy != 0 || sy != 0) begin
            ax = cy; ay = sy; z = 0;
            bx = vx * 256; by = vy * 256;
            // Left half plane: pre-rotate by a quarter turn.
            if (ax < 0) begin
                up = ay >= 0;
                tx = ax;
                if (up) begin
                    ax = ay; ay = -tx;
                end else begin
                    ax = -ay; ay = tx;
                end
                z = up ? HALF_PI : -HALF_PI;
                tb = bx;
                if (up != glob) begin
                    bx = by; by = -tb;
                end else begin
                    bx = -by; by = tb;
                end
            end
            for (int i = 0; i < ITERS; i++) begin
                fwd = ay >= 0;
                tx = ax; tb = bx;
                if (fwd) begin
                    ax += shr(ay, i); ay -= shr(tx, i); z += angle_step(i);
                end else begin
                    ax -= shr(ay, i); ay += shr(tx, i); z -= angle_step(i);
                end
                if (fwd != glob) begin
                    bx += shr(by, i); by -= shr(tb, i);
                end else begin
                    bx -= shr(by, i); by += shr(tb, i);
                end
            end
            rx = gain_round(bx, 64'd652032874);
            ry = gain_round(by, 64'd652032874);
            hd = shr(z + 1024, 11);
            if (hd > HEAD_MAX) hd = HEAD_MAX;
            if (hd < -HEAD_MAX) hd = -HEAD_MAX;
        end
        if (glob) begin
            rx += ox; ry += oy;
        end
        if (rx > 64'sd2147483647) begin
            rx = 64'sd2147483647; clip = 1'b1;
        end else if (rx < -64'sd2147483648) begin
            rx = -64'sd2147483648; clip = 1'b1;
        end
        if (ry > 64'sd2147483647) begin
            ry = 64'sd2147483647; clip = 1'b1;
        end else if (ry < -64'sd2147483648) begin
            ry = -64'sd2147483648; clip = 1'b1;
        end
        r.result_x = rx[31:0];
        r.result_y = ry[31:0];
        r.heading = hd[15:0];
        r.clipped = clip;
        return r;
    endfunction

    assign o_pending = transform_q.size();

    // Record expectations on input transfers and compare output transfers.
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            o_errors <= 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                transform_q.push_back(predict_transform(i_in_data));
            end
            if (i_out_valid && i_out_ready) begin
                if (transform_q.size() == 0) begin
                    if (o_errors < 10)
                        $display("Unexpected output transfer: %p", i_out_data);
                    o_errors <= o_errors + 1;
                end else begin
                    want = transform_q.pop_front();
                    if (want !== i_out_data) begin
                        if (o_errors < 10)
                            $display("Mismatch: expected %p, got %p", want, i_out_data);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb: testbench for the planar frame transform.
// Drives directed corner cases and random points with random idling on both
// channels; the checker predicts and compares every result.
// ============================================================================
module tb;
    import pft_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_data;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_data;
    int        errors;
    int        pending;
    int        send_idle_pct;
    int        recv_idle_pct;

    planar_frame_transform uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_ready (in_ready),
        .i_data  (in_data),
        .o_valid (out_valid),
        .i_ready (out_ready),
        .o_data  (out_data)
    );

    pft_checker checker_i (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Receiver stall pattern.
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic signed [15:0] rand_quat();
        case ($urandom_range(3))
            0: return 16'($signed($urandom_range(32768)) - 16384);
            1: return 16'($urandom);
            2: return 16'sd0;
            default: return 16'($signed($urandom_range(64)) - 32);
        endcase
    endfunction

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(3))
            0: return 32'($urandom);
            1: return 32'($signed($urandom_range(2000000)) - 1000000);
            2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(65535)) - 32768) <<< 16;
        endcase
    endfunction

    // Present one item and hold it until the transfer completes.
    task automatic send_point(input t_in_item d);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= d;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_directed(input logic f, input logic signed [31:0] px,
                                 input logic signed [31:0] py,
                                 input logic signed [31:0] ox,
                                 input logic signed [31:0] oy,
                                 input logic signed [15:0] qx,
                                 input logic signed [15:0] qy,
                                 input logic signed [15:0] qz,
                                 input logic signed [15:0] qw);
        t_in_item d;
        d = '{f, px, py, ox, oy, qx, qy, qz, qw};
        send_point(d);
    endtask

    task automatic send_random(input int count);
        t_in_item d;
        for (int i = 0; i < count; i++) begin
            d.func = 1'($urandom_range(1));
            d.point_x = rand_coord();
            d.point_y = rand_coord();
            d.origin_x = rand_coord();
            d.origin_y = rand_coord();
            d.quat_x = rand_quat();
            d.quat_y = rand_quat();
            d.quat_z = rand_quat();
            d.quat_w = rand_quat();
            send_point(d);
        end
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        send_idle_pct = 11;
        recv_idle_pct = 82;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        // Directed: identity, zero quaternion, quarter and half turns,
        // left-half-plane yaw, saturation and extreme fields.
        for (int f = 0; f < 2; f++) begin
            send_directed(1'(f), 32'sd65536, 32'sd131072, 32'sd1000, -32'sd2000,
                          0, 0, 0, 16384);
            send_directed(1'(f), 32'sd65536, -32'sd65536, 32'sd500, 32'sd700,
                          0, 0, 0, 0);
            send_directed(1'(f), 32'sd300000, 32'sd5, 0, 0, 0, 0, 11585, 11585);
            send_directed(1'(f), -32'sd300000, 32'sd77, 32'sd9, 32'sd9, 0, 0, 16384, 0);
            send_directed(1'(f), 32'sd123456, 32'sd654321, 0, 0, 0, 0, -16384, 0);
            send_directed(1'(f), 32'sd40000, -32'sd90000, 0, 0, 0, 0, 16000, -3000);
            send_directed(1'(f), 32'sd40000, -32'sd90000, 0, 0, 0, 0, -16000, -3000);
            send_directed(1'(f), 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                          32'h8000_0000, 0, 0, 0, 16384);
            send_directed(1'(f), 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                          32'h7FFF_FFFF, 16384, -16384, 16384, -16384);
            send_directed(1'(f), 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                          32'h8000_0000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
            send_directed(1'(f), -32'sd1, 32'sd1, 32'sd0, 32'sd0, 16'hFFFF, 0, 1, 0);
        end
        send_random(140);
        // Hold off until every outstanding result has drained.
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        send_idle_pct = 82;
        recv_idle_pct = 11;
        send_random(140);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(150);
        in_valid <= 1'b0;
        recv_idle_pct = 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
